### design/mprs_pkg.sv
// ----------------------------------------------------------------------------
// mprs_pkg - shared types and constants for the Merkle path root engine
// SHA-256 round constants, initial hash value, sequencer states, word types.
// ----------------------------------------------------------------------------
package mprs_pkg;

    localparam int WORD_W   = 32;
    localparam int TDATA_W  = 256;
    localparam int TUSER_W  = 2;
    localparam int ROUNDS_W = 6;

    // tuser bit positions
    localparam int USER_CMD = 0;
    localparam int USER_DIR = 1;

    // command codes
    localparam logic CMD_LEAF  = 1'b0;
    localparam logic CMD_LEVEL = 1'b1;

    localparam logic [ROUNDS_W-1:0] LAST_ROUND = '1;

    typedef logic [WORD_W-1:0]      t_word;
    typedef logic [7:0][WORD_W-1:0]  t_hash;   // word 0 in the low bits
    typedef logic [15:0][WORD_W-1:0] t_block;  // word 0 in the low bits

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic busy;
        logic res_valid;
    } t_core_stat;

    localparam t_hash INIT_H = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam t_word ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

### design/merkle_path_root_sha256.sv
// ----------------------------------------------------------------------------
// merkle_path_root_sha256 - Merkle authentication path walker
// Hashes a leaf digest up a path of siblings with SHA-256 compressions.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): tdata carries a 256-bit digest, tuser carries
//   cmd (bit 0) and direction (bit 1), tlast marks the final level.
//   cmd = leaf loads the current digest, no output, tready stays high.
//   cmd = level forms a 512-bit block from the current digest and the sibling
//   (direction 1: sibling first) and runs one SHA-256 compression from the
//   standard IV, no padding. The output becomes the current digest.
//   A level item with tlast set also sends the new digest on m_axis.
// Sequence:
//   A level item holds off the next accept until it is done: the accept/load
//   cycle, 64 rounds through one shared round unit, and the final-add cycle,
//   which waits while a root cannot yet be taken. Root appears on m_axis
//   the cycle after the final add.
// Reset: current digest clears to all zero words, no output pending.
// Stall: the root sits in an output register; input keeps going while it
//   waits. A second root waits in the final-add cycle until the first is taken.
// ----------------------------------------------------------------------------
module merkle_path_root_sha256 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // digest_w0, digest_w1, digest_w2, digest_w3 (64 bits each, from bit 0)
    input  logic [mprs_pkg::TDATA_W-1:0]  i_s_axis_tdata,
    // cmd, direction
    input  logic [mprs_pkg::TUSER_W-1:0]  i_s_axis_tuser,
    input  logic                          i_s_axis_tlast,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // root_w0, root_w1, root_w2, root_w3 (64 bits each, from bit 0)
    output logic [mprs_pkg::TDATA_W-1:0]  o_m_axis_tdata
);

    mprs_pkg::t_hash      r_digest;
    logic                 r_last;
    logic                 r_out_valid;
    logic [mprs_pkg::TDATA_W-1:0] r_out_data;

    mprs_pkg::t_hash      w_sib;
    mprs_pkg::t_block     w_block;
    mprs_pkg::t_core_stat w_stat;
    mprs_pkg::t_hash      w_res;
    logic                 w_in_acc;
    logic                 w_start;
    logic                 w_res_ready;
    logic                 w_res_take;
    logic [mprs_pkg::TDATA_W-1:0] w_res_packed;

    assign o_s_axis_tready = !w_stat.busy;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_start         = w_in_acc
                           && (i_s_axis_tuser[mprs_pkg::USER_CMD] == mprs_pkg::CMD_LEVEL);

    // a non-final result never blocks; a root needs the output register free
    assign w_res_ready = !r_last || !r_out_valid || i_m_axis_tready;
    assign w_res_take  = w_stat.res_valid && w_res_ready;

    // unpack: even word in the upper half of each 64-bit lane
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_sib[2*i]     = i_s_axis_tdata[64*i+32 +: 32];
            w_sib[2*i+1]   = i_s_axis_tdata[64*i    +: 32];
            w_res_packed[64*i+32 +: 32] = w_res[2*i];
            w_res_packed[64*i    +: 32] = w_res[2*i+1];
        end
        if (i_s_axis_tuser[mprs_pkg::USER_DIR]) begin
            w_block = {r_digest, w_sib};
        end else begin
            w_block = {w_sib, r_digest};
        end
    end

    mprs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_block     (w_block),
        .i_res_ready (w_res_ready),
        .o_stat      (w_stat),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digest    <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                if (i_s_axis_tuser[mprs_pkg::USER_CMD] == mprs_pkg::CMD_LEAF) begin
                    r_digest <= w_sib;
                end else begin
                    r_last <= i_s_axis_tlast;
                end
            end else if (w_res_take) begin
                r_digest <= w_res;
            end

            if (w_res_take && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take && r_last) begin
            r_out_data <= w_res_packed;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

### design/mprs_round.sv
// ----------------------------------------------------------------------------
// mprs_round - one SHA-256 round
// Updates the eight working words and forms the next schedule word.
// ----------------------------------------------------------------------------
module mprs_round (
    input  mprs_pkg::t_hash  i_v,
    input  mprs_pkg::t_block i_w,
    input  mprs_pkg::t_word  i_k,
    output mprs_pkg::t_hash  o_v,
    output mprs_pkg::t_word  o_w_new
);

    mprs_pkg::t_word w_bs0, w_bs1, w_ch, w_maj, w_t1, w_t2, w_sig0, w_sig1;

    always_comb begin
        w_bs1 = {i_v[4][5:0], i_v[4][31:6]} ^ {i_v[4][10:0], i_v[4][31:11]}
              ^ {i_v[4][24:0], i_v[4][31:25]};
        w_ch  = (i_v[4] & i_v[5]) ^ (~i_v[4] & i_v[6]);
        w_t1  = i_v[7] + w_bs1 + w_ch + i_k + i_w[0];
        w_bs0 = {i_v[0][1:0], i_v[0][31:2]} ^ {i_v[0][12:0], i_v[0][31:13]}
              ^ {i_v[0][21:0], i_v[0][31:22]};
        w_maj = (i_v[0] & i_v[1]) ^ (i_v[0] & i_v[2]) ^ (i_v[1] & i_v[2]);
        w_t2  = w_bs0 + w_maj;

        o_v[7] = i_v[6];
        o_v[6] = i_v[5];
        o_v[5] = i_v[4];
        o_v[4] = i_v[3] + w_t1;
        o_v[3] = i_v[2];
        o_v[2] = i_v[1];
        o_v[1] = i_v[0];
        o_v[0] = w_t1 + w_t2;

        // schedule: w[t+16] from the 16-word window
        w_sig0 = {i_w[1][6:0], i_w[1][31:7]} ^ {i_w[1][17:0], i_w[1][31:18]}
               ^ {3'b000, i_w[1][31:3]};
        w_sig1 = {i_w[14][16:0], i_w[14][31:17]} ^ {i_w[14][18:0], i_w[14][31:19]}
               ^ {10'd0, i_w[14][31:10]};
        o_w_new = i_w[0] + w_sig0 + i_w[9] + w_sig1;
    end

endmodule

### design/mprs_core.sv
// ----------------------------------------------------------------------------
// mprs_core - iterative SHA-256 compression
// One block, 64 rounds through a shared round unit, then the final add.
// ----------------------------------------------------------------------------
module mprs_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  mprs_pkg::t_block     i_block,
    input  logic                 i_res_ready,
    output mprs_pkg::t_core_stat o_stat,
    output mprs_pkg::t_hash      o_res
);

    mprs_pkg::t_state r_state, n_state;
    logic [mprs_pkg::ROUNDS_W-1:0] r_cnt;
    mprs_pkg::t_block r_w;
    mprs_pkg::t_hash  r_v;
    mprs_pkg::t_hash  w_v_next;
    mprs_pkg::t_word  w_new;

    mprs_round u_round (
        .i_v     (r_v),
        .i_w     (r_w),
        .i_k     (mprs_pkg::ROUND_K[r_cnt]),
        .o_v     (w_v_next),
        .o_w_new (w_new)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mprs_pkg::ST_IDLE: begin
                if (i_start) n_state = mprs_pkg::ST_ROUND;
            end
            mprs_pkg::ST_ROUND: begin
                if (r_cnt == mprs_pkg::LAST_ROUND) n_state = mprs_pkg::ST_FINAL;
            end
            mprs_pkg::ST_FINAL: begin
                if (i_res_ready) n_state = mprs_pkg::ST_IDLE;
            end
            default: n_state = mprs_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_stat.busy      = (r_state != mprs_pkg::ST_IDLE);
        o_stat.res_valid = (r_state == mprs_pkg::ST_FINAL);
        for (int i = 0; i < 8; i++) begin
            o_res[i] = mprs_pkg::INIT_H[i] + r_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mprs_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == mprs_pkg::ST_IDLE && i_start) begin
                r_cnt <= '0;
            end else if (r_state == mprs_pkg::ST_ROUND) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mprs_pkg::ST_IDLE && i_start) begin
            r_w <= i_block;
            r_v <= mprs_pkg::INIT_H;
        end else if (r_state == mprs_pkg::ST_ROUND) begin
            r_v <= w_v_next;
            r_w <= {w_new, r_w[15:1]};
        end
    end

endmodule
